>>> design/per_cpu_page_free_list_allocator_macros.svh
// Assertion macros shared by the allocator checker.
// Depends on nothing; the including module must provide clock and reset.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define PPFL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ppfl: assertion failed");

// Checked at every rising clock edge, reset included.
`define PPFL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("ppfl: assertion failed");

`endif

>>> design/ppfl_pkg.sv
// Shared constants, codes and helper functions of the per-CPU page allocator.
// Has no dependencies; imported by the top level and by the checker.
`default_nettype none

package ppfl_pkg;

   // Sizing of the allocator.
   localparam int NUM_CPUS   = 8;
   localparam int MAX_PAGES  = 32768;
   localparam int PAGE_BYTES = 4096;

   // Field widths fixed by the interface.
   localparam int ID_W      = 4;
   localparam int ADDR_W    = 34;
   localparam int REG_W     = 35;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Derived widths.
   localparam int CPU_W      = $clog2(NUM_CPUS);
   localparam int SLOT_W     = $clog2(MAX_PAGES);
   localparam int LINK_W     = SLOT_W + 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_NUM_W = REG_W - PAGE_SHIFT;
   localparam int GSUM_W     = PAGE_NUM_W + 1;
   localparam int WRAP_STEPS = (1 << ID_W) / NUM_CPUS;

   // Request opcodes.
   localparam logic OP_FREE  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_FREED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OOM   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP        = 1'd1;

   // Register reset values.
   localparam logic [REG_W-1:0] FIRST_FREE_RESET = 35'h0_8000_0000;
   localparam logic [REG_W-1:0] TOP_RESET        = 35'h0_8800_0000;

   // Reduces a CPU id modulo the CPU count by repeated compare and subtract.
   function automatic logic [CPU_W-1:0] cpu_wrap(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] v;
      v = id;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (v >= ID_W'(NUM_CPUS)) begin
            v = v - ID_W'(NUM_CPUS);
         end
      end
      return CPU_W'(v);
   endfunction

endpackage

`default_nettype wire

>>> design/ppfl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies; used for the page link store.
`default_nettype none

module ppfl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/per_cpu_page_free_list_allocator.sv
// Per-CPU page free-list allocator: top level with control, list heads and registers.
// Depends on ppfl_pkg and instantiates ppfl_ram for the page link store.
//
// Usage. Request beats arrive on req_* (valid/ready). A free beat (opcode 0)
// pushes req_page_address onto the list of CPU req_cpu_id modulo the CPU
// count; an allocate beat (opcode 1) pops from that CPU's list, or steals
// from CPUs id+1, id+2, ... in wrapped order when it is empty. Every request
// yields exactly one response beat on rsp_*: freed, allocated (with address
// and source CPU), out of memory, or bad free address. The csr_* port writes
// the first free address and the top address; the user must write it only
// while the block is idle, as the block itself has no check for this.
// Timing. One request is in flight at a time. A free or an out-of-memory
// allocate passes through the check, execute and done states, and the done
// state loads the output register; a successful allocate adds the link
// state for the link store read. The block takes a new beat only in idle.
// Reset empties every list and restores the register defaults; the link store
// is not cleared, since an entry is only read after it has been written.
// If the receiver stalls, the finished response waits in the output register
// while the next request is accepted and processed; that request then waits
// in its final state until the output register frees up.
`default_nettype none

module per_cpu_page_free_list_allocator
   import ppfl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [ID_W-1:0]       req_cpu_id,
   input  wire logic [ADDR_W-1:0]     req_page_address,
   // Response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [STATUS_W-1:0]   rsp_status,
   output logic      [ADDR_W-1:0]     rsp_granted_address,
   output logic      [ID_W-1:0]       rsp_source_cpu,
   // Register write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [REG_W-1:0]      csr_wdata
);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_EXEC  = 5'b00100,
      S_LINK  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Captured request.
   logic                  op_ff,   op_in;
   logic [CPU_W-1:0]      cpu_ff,  cpu_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;

   // Results of the check step.
   logic                  bad_ff,   bad_in;
   logic [PAGE_NUM_W-1:0] diff_ff,  diff_in;
   logic                  found_ff, found_in;
   logic [CPU_W-1:0]      src_ff,   src_in;

   // Pending result, waiting for the output register.
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0]     res_addr_ff,   res_addr_in;
   logic [CPU_W-1:0]      res_src_ff,    res_src_in;

   // Output register.
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_addr_ff,   rsp_addr_in;
   logic [CPU_W-1:0]      rsp_src_ff,    rsp_src_in;

   // Configuration registers.
   logic [REG_W-1:0]      first_free_ff, first_free_in;
   logic [REG_W-1:0]      top_ff,        top_in;

   // List heads and their nonempty flags.
   logic [SLOT_W-1:0]     head_ff [NUM_CPUS];
   logic [SLOT_W-1:0]     head_in [NUM_CPUS];
   logic [NUM_CPUS-1:0]   nonempty_ff, nonempty_in;

   // Link store port signals.
   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   logic [LINK_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_addr;
   logic [LINK_W-1:0]     ram_rd_data;

   // Steal search and address arithmetic.
   logic                  hit;
   logic [CPU_W-1:0]      hit_cpu;
   logic [CPU_W:0]        cand;
   logic [GSUM_W-1:0]     grant_page;
   logic [ADDR_W-1:0]     grant_addr;

   ppfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   // Look for the first nonempty list starting at the requesting CPU. The loop
   // runs from the farthest offset down so that the nearest hit wins.
   always_comb begin
      hit     = 1'b0;
      hit_cpu = '0;
      cand    = '0;
      for (int off = NUM_CPUS - 1; off >= 0; off--) begin
         cand = (CPU_W + 1)'(cpu_ff) + (CPU_W + 1)'(off);
         if (cand >= (CPU_W + 1)'(NUM_CPUS)) begin
            cand = cand - (CPU_W + 1)'(NUM_CPUS);
         end
         if (nonempty_ff[cand[CPU_W-1:0]]) begin
            hit     = 1'b1;
            hit_cpu = cand[CPU_W-1:0];
         end
      end
   end

   // The granted address is rebuilt from the current base page and the slot
   // at the head of the source list, then cut to the address width.
   assign grant_page = GSUM_W'(first_free_ff[REG_W-1:PAGE_SHIFT]) + GSUM_W'(head_ff[src_ff]);
   assign grant_addr = {grant_page[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cpu_in        = cpu_ff;
      addr_in       = addr_ff;
      bad_in        = bad_ff;
      diff_in       = diff_ff;
      found_in      = found_ff;
      src_in        = src_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_src_in    = res_src_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_src_in    = rsp_src_ff;
      first_free_in = first_free_ff;
      top_in        = top_ff;
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = diff_ff[SLOT_W-1:0];
      ram_wr_data   = {nonempty_ff[src_ff], head_ff[src_ff]};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff[src_ff];

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_FREE: first_free_in = csr_wdata;
            CSR_TOP:        top_in        = csr_wdata;
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               cpu_in   = cpu_wrap(req_cpu_id);
               addr_in  = req_page_address;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Alignment and range checks; the slot offset is only meaningful
            // when the address is at or above the first free address.
            bad_in = (addr_ff[PAGE_SHIFT-1:0] != '0) ||
                     ({1'b0, addr_ff} < first_free_ff) ||
                     ({1'b0, addr_ff} >= top_ff);
            diff_in = PAGE_NUM_W'(addr_ff[ADDR_W-1:PAGE_SHIFT]) -
                      first_free_ff[REG_W-1:PAGE_SHIFT];
            found_in = hit;
            src_in   = (op_ff == OP_FREE) ? cpu_ff : hit_cpu;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_addr_in = '0;
            res_src_in  = '0;
            state_in    = S_DONE;
            if (op_ff == OP_FREE) begin
               if (bad_ff || (diff_ff >= PAGE_NUM_W'(MAX_PAGES))) begin
                  res_status_in = ST_BAD;
               end else begin
                  // Push: the new slot links to the old head.
                  ram_wr_en           = 1'b1;
                  head_in[src_ff]     = diff_ff[SLOT_W-1:0];
                  nonempty_in[src_ff] = 1'b1;
                  res_status_in       = ST_FREED;
               end
            end else if (!found_ff) begin
               res_status_in = ST_OOM;
            end else begin
               // Pop: fetch the link of the head slot.
               ram_rd_en     = 1'b1;
               res_status_in = ST_ALLOC;
               res_addr_in   = grant_addr;
               res_src_in    = src_ff;
               state_in      = S_LINK;
            end
         end
         S_LINK: begin
            head_in[src_ff]     = ram_rd_data[SLOT_W-1:0];
            nonempty_in[src_ff] = ram_rd_data[SLOT_W];
            state_in            = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_src_in    = res_src_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         nonempty_ff   <= '0;
         first_free_ff <= FIRST_FREE_RESET;
         top_ff        <= TOP_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         nonempty_ff   <= nonempty_in;
         first_free_ff <= first_free_in;
         top_ff        <= top_in;
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cpu_ff        <= cpu_in;
      addr_ff       <= addr_in;
      bad_ff        <= bad_in;
      diff_ff       <= diff_in;
      found_ff      <= found_in;
      src_ff        <= src_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_src_ff    <= res_src_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_src_ff    <= rsp_src_in;
      head_ff       <= head_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_source_cpu      = ID_W'(rsp_src_ff);

endmodule

`default_nettype wire

>>> design/ppfl_checker.sv
// Port-level checker for the per-CPU page allocator, bound to the top level.
// Depends on ppfl_pkg and per_cpu_page_free_list_allocator_macros.svh.
`default_nettype none
`include "per_cpu_page_free_list_allocator_macros.svh"

module ppfl_checker
   import ppfl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic [ADDR_W-1:0]    rsp_granted_address,
   input wire logic [ID_W-1:0]      rsp_source_cpu
);

   logic                              grant_beat;
   logic                              other_beat;
   logic                              fields_clear;
   logic                              grant_ok;
   logic [STATUS_W+ADDR_W+ID_W-1:0]   rsp_payload;

   assign grant_beat   = rsp_valid && (rsp_status == ST_ALLOC);
   assign other_beat   = rsp_valid && (rsp_status != ST_ALLOC);
   assign fields_clear = (rsp_granted_address == '0) && (rsp_source_cpu == '0);
   assign grant_ok     = (rsp_granted_address[PAGE_SHIFT-1:0] == '0) &&
                         (rsp_source_cpu < ID_W'(NUM_CPUS));
   assign rsp_payload  = {rsp_status, rsp_granted_address, rsp_source_cpu};

   // Only a successful allocate carries an address and a source CPU.
   `PPFL_ASSERT(a_no_grant_fields, other_beat |-> fields_clear)

   // A granted page is page aligned and comes from an existing CPU.
   `PPFL_ASSERT(a_grant_shape, grant_beat |-> grant_ok)

   // One request at a time: the block is busy right after it takes a beat.
   `PPFL_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready)

   // A stalled response beat holds its contents.
   `PPFL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // Reset leaves no response pending.
   `PPFL_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)

endmodule

bind per_cpu_page_free_list_allocator ppfl_checker u_ppfl_checker (.*);

`default_nettype wire

>>> tb/per_cpu_page_free_list_allocator_tb.sv
// Self-checking testbench for the per-CPU page free-list allocator.
// Depends on ppfl_pkg and on the per_cpu_page_free_list_allocator top level.
// A built-in list model predicts each response beat and the monitor checks it.
module per_cpu_page_free_list_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppfl_pkg::*;

   // One request beat as the host issues it.
   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   cpu_id;
      logic [ADDR_W-1:0] page_address;
   } page_request_type;

   // One response beat as the allocator returns it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
      logic [ID_W-1:0]     source_cpu;
   } page_response_type;

   // Upper end of the register range, one past the largest address.
   localparam logic [REG_W-1:0] ADDR_SPAN = REG_W'(1) << ADDR_W;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_opcode       = OP_FREE;
   logic [ID_W-1:0]      req_cpu_id       = '0;
   logic [ADDR_W-1:0]    req_page_address = '0;

   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_granted_address;
   logic [ID_W-1:0]      rsp_source_cpu;

   logic                 csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_FIRST_FREE;
   logic [REG_W-1:0]     csr_wdata        = '0;

   // Request beats waiting to be driven, and responses predicted for beats that
   // the allocator has accepted but not yet answered.
   page_request_type  pending_requests[$];
   page_response_type expected_responses[$];
   page_request_type  live_request;

   // Model copy of the registers and of the free lists. The link entries stay
   // unknown until a free writes them, exactly as in the hardware.
   logic [REG_W-1:0]  first_free_reg;
   logic [REG_W-1:0]  top_reg;
   logic [SLOT_W-1:0] head_slot  [NUM_CPUS];
   logic              has_pages  [NUM_CPUS];
   logic [SLOT_W-1:0] link_slot  [MAX_PAGES];
   logic              link_valid [MAX_PAGES];

   // Percentage of beats after which a side inserts an idle gap or a stall.
   int gap_pct     = 0;
   int send_hold   = 0;
   int recv_hold   = 0;
   int mismatches  = 0;

   per_cpu_page_free_list_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_cpu_id          (req_cpu_id),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_source_cpu      (rsp_source_cpu),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #6 clock = ~clock;

   // Hard stop in case the allocator hangs or drops a beat.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Applies one request to the list model and returns the response it must
   // produce. A free pushes onto the LIFO of the named CPU; an allocate pops
   // from the first non-empty list, starting at the named CPU and wrapping.
   function automatic page_response_type predict_response(input page_request_type r);
      page_response_type res;
      logic [CPU_W-1:0]  start;
      logic [CPU_W-1:0]  c;
      int                off;
      longint unsigned   addr;
      longint unsigned   base;
      longint unsigned   slot;
      logic [SLOT_W-1:0] s;
      res   = '0;
      start = CPU_W'(r.cpu_id % ID_W'(NUM_CPUS));
      addr  = 64'(r.page_address);
      base  = 64'(first_free_reg) / 64'(PAGE_BYTES);
      if (r.opcode == OP_FREE) begin
         slot = addr / 64'(PAGE_BYTES) - base;
         // Unaligned, out of the managed window, or past the end of the link
         // store: rejected and nothing changes.
         if ((addr % 64'(PAGE_BYTES)) != 64'd0 || addr < 64'(first_free_reg) ||
             addr >= 64'(top_reg) || slot >= 64'(MAX_PAGES)) begin
            res.status = ST_BAD;
         end else begin
            s                = SLOT_W'(slot);
            link_slot[s]     = head_slot[start];
            link_valid[s]    = has_pages[start];
            head_slot[start] = s;
            has_pages[start] = 1'b1;
            res.status       = ST_FREED;
         end
      end else begin
         res.status = ST_OOM;
         for (off = 0; off < NUM_CPUS; off++) begin
            c = CPU_W'((int'(start) + off) % NUM_CPUS);
            if (res.status == ST_OOM && has_pages[c]) begin
               s = head_slot[c];
               // The address is rebuilt from the current base page, so a
               // register change re-bases pages that are already listed.
               res.status          = ST_ALLOC;
               res.granted_address = ADDR_W'((base + 64'(s)) * 64'(PAGE_BYTES));
               res.source_cpu      = ID_W'(c);
               head_slot[c]        = link_slot[s];
               has_pages[c]        = link_valid[s];
            end
         end
      end
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return int'($urandom_range(10, 40));
      end
      return int'($urandom_range(1, 3));
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   // A page address that the current registers accept, when one exists.
   function automatic logic [ADDR_W-1:0] pick_page();
      longint unsigned lo;
      longint unsigned hi;
      if (top_reg == '0) begin
         return random_addr();
      end
      lo = (64'(first_free_reg) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
      hi = 64'(first_free_reg) / 64'(PAGE_BYTES) + 64'(MAX_PAGES - 1);
      if ((64'(top_reg) - 64'd1) / 64'(PAGE_BYTES) < hi) begin
         hi = (64'(top_reg) - 64'd1) / 64'(PAGE_BYTES);
      end
      if (lo > hi) begin
         return random_addr();
      end
      return ADDR_W'((lo + 64'($urandom_range(0, int'(hi - lo)))) * 64'(PAGE_BYTES));
   endfunction

   task automatic queue_request(input logic op, input logic [ID_W-1:0] cpu,
                                input logic [ADDR_W-1:0] addr);
      page_request_type r;
      r.opcode       = op;
      r.cpu_id       = cpu;
      r.page_address = addr;
      pending_requests.push_back(r);
   endtask

   // Random traffic: well-formed frees and allocates for the most part, with
   // a share of frees at random, unaligned or out-of-window addresses.
   task automatic queue_random(input int count, input int alloc_pct);
      int               roll;
      logic [ADDR_W-1:0] a;
      repeat (count) begin
         roll = int'($urandom_range(0, 99));
         if (roll < alloc_pct) begin
            queue_request(OP_ALLOC, ID_W'($urandom_range(0, 15)), random_addr());
         end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
            queue_request(OP_FREE, ID_W'($urandom_range(0, 15)), pick_page());
         end else begin
            case ($urandom_range(0, 3))
               0: a = random_addr();
               1: a = pick_page() | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
               2: a = ADDR_W'(first_free_reg) - ADDR_W'(PAGE_BYTES);
               default: a = ADDR_W'(top_reg);
            endcase
            queue_request(OP_FREE, ID_W'($urandom_range(0, 15)), a);
         end
      end
   endtask

   // Register writes happen only while the allocator is idle, so the model
   // copy can change at the same time.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_FIRST_FREE) begin
         first_free_reg = value;
      end else begin
         top_reg = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued beat has been sent and answered, then lets the
   // pipeline settle before returning.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_valid ||
                 expected_responses.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Request driver. A beat is predicted at the edge where it is accepted;
   // valid then stays low only when a gap is due or nothing is queued.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_responses.push_back(predict_response(live_request));
         end
         if (!req_valid || req_ready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               live_request = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= live_request.opcode;
               req_cpu_id       <= live_request.cpu_id;
               req_page_address <= live_request.page_address;
               if ($urandom_range(0, 99) < gap_pct) begin
                  send_hold = gap_len();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every accepted beat is checked field by field against
   // the oldest prediction; ready drops for random stalls of its own.
   always @(posedge clock) begin
      page_response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, status %0d",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_granted_address !== want.granted_address) begin
                  $display("%0t: granted_address expected 0x%0h, got 0x%0h",
                           $time, want.granted_address, rsp_granted_address);
                  mismatches++;
               end
               if (rsp_source_cpu !== want.source_cpu) begin
                  $display("%0t: source_cpu expected %0d, got %0d",
                           $time, want.source_cpu, rsp_source_cpu);
                  mismatches++;
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < gap_pct) begin
               recv_hold = gap_len();
            end
         end
      end
   end

   // Stimulus sequence: phases of traffic, each under its own register setting.
   initial begin
      int               i;
      logic [REG_W-1:0] ff_val;
      logic [REG_W-1:0] top_val;

      first_free_reg = FIRST_FREE_RESET;
      top_reg        = TOP_RESET;
      for (i = 0; i < NUM_CPUS; i++) begin
         head_slot[i] = '0;
         has_pages[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values. Directed beats first: an allocate with every
      // list empty, the first and the last page of the window, frees at the
      // top, below the window, unaligned, at the largest and at the zero
      // address, CPU ids above the CPU count, stealing that wraps around,
      // and a page freed onto two lists so that it is handed out twice.
      gap_pct = 25;
      queue_request(OP_ALLOC, 4'd0,  '0);
      queue_request(OP_FREE,  4'd0,  34'h0_8000_0000);
      queue_request(OP_FREE,  4'd15, 34'h0_87FF_F000);
      queue_request(OP_FREE,  4'd3,  34'h0_8800_0000);
      queue_request(OP_FREE,  4'd3,  34'h0_7FFF_F000);
      queue_request(OP_FREE,  4'd3,  34'h0_8000_0800);
      queue_request(OP_FREE,  4'd3,  34'h3_FFFF_FFFF);
      queue_request(OP_FREE,  4'd3,  34'h0_0000_0000);
      queue_request(OP_ALLOC, 4'd9,  34'h3_FFFF_FFFF);
      queue_request(OP_ALLOC, 4'd7,  '0);
      queue_request(OP_ALLOC, 4'd0,  '0);
      queue_request(OP_FREE,  4'd2,  34'h0_8000_1000);
      queue_request(OP_FREE,  4'd2,  34'h0_8000_2000);
      queue_request(OP_ALLOC, 4'd2,  '0);
      queue_request(OP_FREE,  4'd4,  34'h0_8000_1000);
      queue_request(OP_ALLOC, 4'd2,  '0);
      queue_request(OP_ALLOC, 4'd4,  '0);
      queue_request(OP_ALLOC, 4'd5,  '0);
      queue_random(150, 40);
      wait_idle();

      // Widest window, with pages from the previous phase still listed so
      // that they come back re-based. This stretch runs without any idling.
      gap_pct = 0;
      write_reg(CSR_FIRST_FREE, '0);
      write_reg(CSR_TOP, ADDR_SPAN);
      queue_request(OP_FREE,  4'd1, '0);
      queue_request(OP_FREE,  4'd1, ADDR_W'((MAX_PAGES - 1) * PAGE_BYTES));
      queue_request(OP_FREE,  4'd1, ADDR_W'(MAX_PAGES * PAGE_BYTES));
      queue_request(OP_ALLOC, 4'd1, '0);
      queue_random(150, 45);
      wait_idle();

      // Base at the very top: every free is rejected, and the granted
      // addresses overflow the field and wrap.
      gap_pct = 50;
      write_reg(CSR_FIRST_FREE, ADDR_SPAN);
      queue_random(40, 80);
      wait_idle();

      // Random, possibly unaligned, base with a window of random size.
      gap_pct = 25;
      ff_val  = REG_W'(random_addr());
      top_val = ff_val + REG_W'($urandom_range(1, 40000) * PAGE_BYTES +
                                $urandom_range(0, PAGE_BYTES - 1));
      if (top_val > ADDR_SPAN) begin
         top_val = ADDR_SPAN;
      end
      write_reg(CSR_FIRST_FREE, ff_val);
      write_reg(CSR_TOP, top_val);
      queue_random(150, 50);
      wait_idle();

      // Empty window: nothing can be freed at all.
      gap_pct = 10;
      write_reg(CSR_FIRST_FREE, '0);
      write_reg(CSR_TOP, '0);
      queue_random(20, 30);
      wait_idle();

      // Tiny window of sixteen pages, so repeated frees of the same page are
      // common and lists may share pages or form loops.
      gap_pct = 40;
      ff_val  = REG_W'(random_addr());
      top_val = ff_val + REG_W'(16 * PAGE_BYTES);
      if (top_val > ADDR_SPAN) begin
         top_val = ADDR_SPAN;
      end
      write_reg(CSR_FIRST_FREE, ff_val);
      write_reg(CSR_TOP, top_val);
      queue_random(100, 45);
      wait_idle();

      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> per_cpu_page_free_list_allocator.f
+incdir+design
design/ppfl_pkg.sv
design/ppfl_ram.sv
design/per_cpu_page_free_list_allocator.sv
design/ppfl_checker.sv
tb/per_cpu_page_free_list_allocator_tb.sv
